// ===== src/gsvsnr_pkg.sv =====
package gsvsnr_pkg;

    // report geometry
    localparam int SNRS_PER_REPORT = 4;
    localparam int SNR_FIELDS      = 4;
    localparam int SNR_W           = 7;
    localparam int LEVEL_W         = 4;
    localparam int HOLDOFF_W       = 8;
    localparam int MISS_W          = 9;

    localparam logic [SNR_W-1:0]     SNR_MAX       = 7'd99;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 8'd4;

    // reciprocal of ten for the level conversion, exact for 7-bit inputs
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int DIV10_W     = 15;

    // operation codes
    typedef enum logic {
        OP_REPORT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    // per-lane finding
    typedef struct packed {
        logic [SNR_W-1:0] snr;
        logic             seen;
    } lane_t;

    // strongest and second strongest snr
    typedef struct packed {
        logic [SNR_W-1:0] high;
        logic [SNR_W-1:0] low;
    } pair_t;

    // snr divided by ten
    function automatic logic [LEVEL_W-1:0] div10(input logic [SNR_W-1:0] v);
        logic [DIV10_W-1:0] prod;
        prod = DIV10_W'(v) * DIV10_W'(DIV10_MUL);
        return prod[DIV10_SHIFT +: LEVEL_W];
    endfunction

endpackage

// ===== src/gsvsnr_lane.sv =====
module gsvsnr_lane (
    input  logic [gsvsnr_pkg::SNR_W-1:0] snr_raw,
    output gsvsnr_pkg::lane_t            lane
);
    import gsvsnr_pkg::*;

    // saturate and flag a present satellite
    always_comb
    begin
        lane.snr  = (snr_raw > SNR_MAX) ? SNR_MAX : snr_raw;
        lane.seen = (lane.snr != '0);
    end

endmodule

// ===== src/gsvsnr_merge.sv =====
module gsvsnr_merge (
    input  gsvsnr_pkg::pair_t                                  pair_in,
    input  gsvsnr_pkg::lane_t [gsvsnr_pkg::SNRS_PER_REPORT-1:0] lanes,
    output gsvsnr_pkg::pair_t                                  pair_out,
    output logic                                               any_seen
);
    import gsvsnr_pkg::*;

    // fold lane values in report order into the running top two
    always_comb
    begin
        pair_t acc;
        logic  seen;
        acc  = pair_in;
        seen = 1'b0;
        for (int i = 0; i < SNRS_PER_REPORT; i++)
        begin
            if (lanes[i].snr >= acc.high)
            begin
                acc.low  = acc.high;
                acc.high = lanes[i].snr;
            end
            else if (lanes[i].snr > acc.low)
            begin
                acc.low = lanes[i].snr;
            end
            seen = seen | lanes[i].seen;
        end
        pair_out = acc;
        any_seen = seen;
    end

endmodule

// ===== src/gsv_snr_top_two_tracker_core.sv =====
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | op, snr_a, snr_b, snr_c, snr_d
// out      | out_valid / out_stall| strong_level, weak_level, sats_visible
// cfg      | cfg_wr_en            | cfg_wr_data (no_sat_holdoff)
//
// one item per cycle while in_stall is low: lanes saturate each snr, and on
// a report a fold network updates the top two and the visible flag in the
// cycle of the transfer. the result appears on out in the cycle after the
// input transfer, or later while out is stalled.
// an output register plus a skid entry keep input transfers going while out
// is stalled; in_stall rises only once the skid entry is occupied.
// reset clears the summary, the flag and the miss count; holdoff resets to 4.
module gsv_snr_top_two_tracker_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [gsvsnr_pkg::SNR_W-1:0]       snr_a,
    input  logic [gsvsnr_pkg::SNR_W-1:0]       snr_b,
    input  logic [gsvsnr_pkg::SNR_W-1:0]       snr_c,
    input  logic [gsvsnr_pkg::SNR_W-1:0]       snr_d,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gsvsnr_pkg::LEVEL_W-1:0]     strong_level,
    output logic [gsvsnr_pkg::LEVEL_W-1:0]     weak_level,
    output logic                               sats_visible,
    input  logic                               cfg_wr_en,
    input  logic [gsvsnr_pkg::HOLDOFF_W-1:0]   cfg_wr_data
);
    import gsvsnr_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] high_lvl;
        logic [LEVEL_W-1:0] low_lvl;
        logic               visible;
    } result_t;

    logic [HOLDOFF_W-1:0] holdoff_reg;
    pair_t                pair_reg, pair_next;
    logic                 visible_reg, visible_next;
    logic [MISS_W-1:0]    miss_reg, miss_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    result_t              out_data_reg, out_data_next;
    result_t              skid_data_reg, skid_data_next;

    logic [SNR_W-1:0]           field_snr [SNR_FIELDS];
    lane_t [SNRS_PER_REPORT-1:0] lanes;
    pair_t                      fold_pair;
    logic                       fold_seen;
    logic                       in_xfer;
    logic                       out_load;
    result_t                    result;

    assign field_snr[0] = snr_a;
    assign field_snr[1] = snr_b;
    assign field_snr[2] = snr_c;
    assign field_snr[3] = snr_d;

    // one lane per snr slot, slots beyond the fields are absent
    for (genvar g = 0; g < SNRS_PER_REPORT; g++)
    begin : g_lane
        if (g < SNR_FIELDS)
        begin : g_field
            gsvsnr_lane u_lane (
                .snr_raw (field_snr[g]),
                .lane    (lanes[g])
            );
        end
        else
        begin : g_absent
            gsvsnr_lane u_lane (
                .snr_raw ('0),
                .lane    (lanes[g])
            );
        end
    end

    gsvsnr_merge u_merge (
        .pair_in  (pair_reg),
        .lanes    (lanes),
        .pair_out (fold_pair),
        .any_seen (fold_seen)
    );

    assign in_xfer = in_valid && !in_stall;

    // next tracker state and the result of this item
    always_comb
    begin
        pair_next    = pair_reg;
        visible_next = visible_reg;
        miss_next    = miss_reg;
        if (op_t'(op) == OP_READ)
        begin
            pair_next = '0;
        end
        else
        begin
            pair_next = fold_pair;
            if (fold_seen)
            begin
                visible_next = 1'b1;
                miss_next    = '0;
            end
            else if (visible_reg)
            begin
                if (miss_reg > MISS_W'(holdoff_reg))
                    visible_next = 1'b0;
                else
                    miss_next = miss_reg + MISS_W'(1);
            end
        end
        if (op_t'(op) == OP_READ)
        begin
            result.high_lvl = div10(pair_reg.high);
            result.low_lvl  = div10(pair_reg.low);
        end
        else
        begin
            result.high_lvl = '0;
            result.low_lvl  = '0;
        end
        result.visible = visible_next;
    end

    // output register with one skid entry
    always_comb
    begin
        out_load        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_xfer)
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_xfer)
        begin
            skid_data_next  = result;
            skid_valid_next = 1'b1;
        end
    end

    // control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg    <= HOLDOFF_RESET;
            pair_reg       <= '0;
            visible_reg    <= 1'b0;
            miss_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                holdoff_reg <= cfg_wr_data;
            if (in_xfer)
            begin
                pair_reg    <= pair_next;
                visible_reg <= visible_next;
                miss_reg    <= miss_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign strong_level = out_data_reg.high_lvl;
    assign weak_level   = out_data_reg.low_lvl;
    assign sats_visible = out_data_reg.visible;

endmodule

// ===== src/gsvsnr_check.sv =====
module gsvsnr_check (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       op,
    input logic [6:0] snr_a,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] strong_level,
    input logic [3:0] weak_level,
    input logic       sats_visible
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(strong_level)
            && $stable(weak_level) && $stable(sats_visible))
        else $error("stalled result changed");

    // a transfer into an empty block shows up on the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> out_valid)
        else $error("result missing after transfer");

    // a report with a present satellite flags visible and carries no levels
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid && !op && snr_a != 7'd0
        |=> sats_visible && strong_level == 4'd0 && weak_level == 4'd0)
        else $error("report result wrong");

    // levels stay in range and ordered
    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> strong_level <= 4'd9 && weak_level <= strong_level)
        else $error("level out of range");

    // input backpressure only follows a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without output stall");

endmodule

bind gsv_snr_top_two_tracker_core gsvsnr_check u_gsvsnr_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .snr_a        (snr_a),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .strong_level (strong_level),
    .weak_level   (weak_level),
    .sats_visible (sats_visible)
);
